// File: rtl/kwn_pkg.sv
// ----------------------------------------------------------------------------
// Keyed wait/notify table package
// Shared sizes, operation and status codes, transaction types and the
// lowest-set-bit search used on the slot flag vectors.
// ----------------------------------------------------------------------------
package kwn_pkg;

  // Table size and the widths that follow from it.
  localparam int SLOTS      = 64;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OUT_SLOT_W = 6;
  localparam int ID_W       = 32;
  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 7;
  localparam int ENTRY_W    = ID_W + KEY_W;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_WAIT    = 2'd0,
    OP_NOTIFY  = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_ASYNC     = 2'd0,
    STAT_BLOCKING  = 2'd1,
    STAT_CANCELLED = 2'd2
  } status_t;

  // Input transaction.
  typedef struct packed {
    op_t                opcode;
    logic [ID_W-1:0]    req_id;
    logic [KEY_W-1:0]   wait_key;
    logic               is_blocking;
    logic [COUNT_W-1:0] wake_count;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [ID_W-1:0]       done_id;
    logic [OUT_SLOT_W-1:0] slot_index;
    status_t               status;
    logic                  last;
  } out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t                op;
    logic [ID_W-1:0]    id;
    logic [KEY_W-1:0]   key;
    logic               blocking;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/keyed_wait_notify_table.sv
// ----------------------------------------------------------------------------
// Keyed wait/notify waiter table
// Records waiters by id and key, releases them on notify and withdraws or
// frees them on cancel and release.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an input transaction is taken at a rising edge where start
//   is high and busy is low. Busy rises only when the two-entry command queue
//   is full; transactions that can have no effect are dropped at the door.
//   Result channel: each result is shown for one cycle with out_strobe high;
//   the receiver cannot stall it. The final result of a command carries last.
//   Commands: a wait needs no scan in the back end. Notify, cancel and release
//   scan the occupied slots through the id/key RAM, one slot per cycle (only
//   the undispatched occupied slots for notify), and stop early once the wake
//   count is spent or an id match is found. The single RAM read port sets
//   this rate. Each result is held until the scan finds the next match or
//   ends, so that the final one can carry last.
//   Reset: rst_n low for one clock empties the table and the queue at once.
// ----------------------------------------------------------------------------
module keyed_wait_notify_table import kwn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front end: accept, classify and queue.
  kwn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: slot table and scan engine.
  kwn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// File: rtl/kwn_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kwn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on demand, read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/kwn_front.sv
// ----------------------------------------------------------------------------
// Keyed wait/notify table front end
// Accepts input transactions, drops the ones that can have no effect and
// queues the rest as commands for the back end.
// ----------------------------------------------------------------------------
module kwn_front import kwn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  logic              keep;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign busy      = (cnt_r == QCNT_W'(QDEPTH));
  assign accept    = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign pop       = cmd_pop && cmd_valid;

  // Classify: a wait needs an id and a key, a notify a key, the others an id.
  always_comb begin
    case (in_item.opcode)
      OP_WAIT:   keep = (in_item.req_id != '0) && (in_item.wait_key != '0);
      OP_NOTIFY: keep = (in_item.wait_key != '0);
      default:   keep = (in_item.req_id != '0);
    endcase
  end

  // Build the command; a wake count of zero means one.
  always_comb begin
    new_cmd.op       = in_item.opcode;
    new_cmd.id       = in_item.req_id;
    new_cmd.key      = in_item.wait_key;
    new_cmd.blocking = in_item.is_blocking;
    new_cmd.count    = (in_item.wake_count == '0) ? COUNT_W'(1) : in_item.wake_count;
  end

  assign push = accept && keep;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// File: rtl/kwn_back.sv
// ----------------------------------------------------------------------------
// Keyed wait/notify table back end
// Holds the slot flags and the id/key RAM, and carries out one command at a
// time; all but waits scan the candidate slots one RAM read per cycle.
// ----------------------------------------------------------------------------
module kwn_back import kwn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_strobe,
  output out_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [SLOTS-1:0]   disp_r, disp_nxt;
  logic [SLOTS-1:0]   blk_r, blk_nxt;
  logic [SLOTS-1:0]   cand_r, cand_nxt;
  op_t                op_r, op_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0]  rd_slot_r, rd_slot_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [ID_W-1:0]    pend_id_r, pend_id_nxt;
  logic [SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;
  status_t            pend_stat_r, pend_stat_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_t               out_r, out_nxt;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [SLOT_W-1:0]  free_idx;
  logic               free_any;
  logic [SLOT_W-1:0]  cand_idx;
  logic               cand_any;
  logic               hit_id;
  logic               hit_key;
  logic               stop;

  // Each entry holds the waiter id above its key.
  kwn_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign free_idx  = first_set(~valid_r);
  assign free_any  = |(~valid_r);
  assign cand_idx  = first_set(cand_r);
  assign cand_any  = |cand_r;
  assign ram_raddr = cand_idx;
  assign hit_id    = (ram_rdata[ENTRY_W-1:KEY_W] == id_r);
  assign hit_key   = (ram_rdata[KEY_W-1:0] == key_r);

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // Command sequencer.
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    disp_nxt       = disp_r;
    blk_nxt        = blk_r;
    cand_nxt       = cand_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    key_nxt        = key_r;
    left_nxt       = left_r;
    rd_vld_nxt     = rd_vld_r;
    rd_slot_nxt    = rd_slot_r;
    pend_vld_nxt   = pend_vld_r;
    pend_id_nxt    = pend_id_r;
    pend_slot_nxt  = pend_slot_r;
    pend_stat_nxt  = pend_stat_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = free_idx;
    ram_wdata      = {cmd.id, cmd.key};
    stop           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_WAIT) begin
            // A wait takes the lowest free slot right away.
            if (free_any) begin
              valid_nxt[free_idx] = 1'b1;
              disp_nxt[free_idx]  = 1'b0;
              blk_nxt[free_idx]   = cmd.blocking;
              ram_we              = 1'b1;
            end
          end else begin
            op_nxt       = cmd.op;
            id_nxt       = cmd.id;
            key_nxt      = cmd.key;
            left_nxt     = cmd.count;
            cand_nxt     = (cmd.op == OP_NOTIFY) ? (valid_r & ~disp_r) : valid_r;
            rd_vld_nxt   = 1'b0;
            pend_vld_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Check the entry read in the previous cycle.
        if (rd_vld_r) begin
          if (op_r == OP_NOTIFY && hit_key) begin
            // The older pending result is now known not to be the last one.
            if (pend_vld_r) begin
              out_strobe_nxt     = 1'b1;
              out_nxt.done_id    = pend_id_r;
              out_nxt.slot_index = OUT_SLOT_W'(pend_slot_r);
              out_nxt.status     = pend_stat_r;
              out_nxt.last       = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_id_nxt   = ram_rdata[ENTRY_W-1:KEY_W];
            pend_slot_nxt = rd_slot_r;
            if (blk_r[rd_slot_r]) begin
              pend_stat_nxt       = STAT_BLOCKING;
              disp_nxt[rd_slot_r] = 1'b1;
            end else begin
              pend_stat_nxt        = STAT_ASYNC;
              valid_nxt[rd_slot_r] = 1'b0;
              disp_nxt[rd_slot_r]  = 1'b0;
            end
            left_nxt = left_r - 1'b1;
            stop     = (left_r == COUNT_W'(1));
          end else if (op_r == OP_CANCEL && hit_id) begin
            // Only the lowest slot holding the id counts.
            stop = 1'b1;
            if (!disp_r[rd_slot_r]) begin
              valid_nxt[rd_slot_r] = 1'b0;
              pend_vld_nxt         = 1'b1;
              pend_id_nxt          = id_r;
              pend_slot_nxt        = rd_slot_r;
              pend_stat_nxt        = STAT_CANCELLED;
            end
          end else if (op_r == OP_RELEASE && hit_id) begin
            stop                 = 1'b1;
            valid_nxt[rd_slot_r] = 1'b0;
            disp_nxt[rd_slot_r]  = 1'b0;
            blk_nxt[rd_slot_r]   = 1'b0;
          end
        end

        // Issue the next candidate read or wrap up.
        if (stop || !cand_any) begin
          rd_vld_nxt = 1'b0;
          state_nxt  = S_FINISH;
        end else begin
          rd_vld_nxt         = 1'b1;
          rd_slot_nxt        = cand_idx;
          cand_nxt[cand_idx] = 1'b0;
        end
      end

      S_FINISH: begin
        // The pending result is the final one of this command.
        if (pend_vld_r) begin
          out_strobe_nxt     = 1'b1;
          out_nxt.done_id    = pend_id_r;
          out_nxt.slot_index = OUT_SLOT_W'(pend_slot_r);
          out_nxt.status     = pend_stat_r;
          out_nxt.last       = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      disp_r       <= '0;
      blk_r        <= '0;
      rd_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      disp_r       <= disp_nxt;
      blk_r        <= blk_nxt;
      rd_vld_r     <= rd_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    key_r       <= key_nxt;
    left_r      <= left_nxt;
    rd_slot_r   <= rd_slot_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_stat_r <= pend_stat_nxt;
    out_r       <= out_nxt;
  end

`ifndef ASSERT_OFF
  // A dispatched mark is only ever kept on an occupied slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((disp_r & ~valid_r) == '0))
    else $error("dispatched mark on a free slot");

  // A scan never runs with its wake budget used up.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (left_r != '0))
    else $error("scan running with zero wake budget");

  // Reads in flight only exist while scanning.
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN))
    else $error("entry read outstanding outside a scan");

  // The final result of a command is followed by a quiet cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.last) |=> !out_strobe_r)
    else $error("result right after a final result");

  // A cancellation is always the only result of its command.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.status == STAT_CANCELLED) |-> out_r.last)
    else $error("cancel result not marked last");
`endif

endmodule

// File: bench/kwn_checker.sv
// ----------------------------------------------------------------------------
// Waiter table checker
// Watches the command and result channels of the keyed wait/notify table.
// It keeps its own copy of the waiter table, works out the results that each
// accepted command must cause, and compares every result field by field.
// ----------------------------------------------------------------------------
module kwn_checker import kwn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_item,
  input  logic out_strobe,
  input  out_t out_item,
  input  logic end_of_test,
  output int   mismatches,
  output int   results_due,
  output int   results_seen
);

  // Shadow of the waiter table.
  logic             waiter_live   [SLOTS];
  logic             waiter_woken  [SLOTS];
  logic             waiter_blocks [SLOTS];
  logic [ID_W-1:0]  waiter_id     [SLOTS];
  logic [KEY_W-1:0] waiter_key    [SLOTS];

  // Wakeups and cancellations still owed by the block, oldest first.
  out_t wakeups_due[$];
  out_t due;
  logic leftovers_reported = 1'b0;

  // One line per mismatch.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("kwn_checker: mismatch at %0t: %s", $time, msg);
  endtask

  // Lowest live slot that holds the id, or -1.
  function automatic int lowest_live_slot(input logic [ID_W-1:0] id);
    for (int s = 0; s < SLOTS; s++) begin
      if (waiter_live[s] && waiter_id[s] == id) begin
        return s;
      end
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and queue the results it causes.
  task automatic predict_command(input in_t cmd);
    out_t burst[$];
    out_t r;
    int   slot;
    int   limit;
    logic placed;
    placed = 1'b0;
    case (cmd.opcode)
      OP_WAIT: begin
        if (cmd.req_id != '0 && cmd.wait_key != '0) begin
          for (int s = 0; s < SLOTS && !placed; s++) begin
            if (!waiter_live[s]) begin
              waiter_live[s]   = 1'b1;
              waiter_woken[s]  = 1'b0;
              waiter_blocks[s] = cmd.is_blocking;
              waiter_id[s]     = cmd.req_id;
              waiter_key[s]    = cmd.wait_key;
              placed           = 1'b1;
            end
          end
        end
      end
      OP_NOTIFY: begin
        if (cmd.wait_key != '0) begin
          limit = (cmd.wake_count == '0) ? 1 : int'(cmd.wake_count);
          for (int s = 0; s < SLOTS && burst.size() < limit; s++) begin
            if (waiter_live[s] && !waiter_woken[s] && waiter_key[s] == cmd.wait_key) begin
              waiter_woken[s] = 1'b1;
              r.done_id    = waiter_id[s];
              r.slot_index = OUT_SLOT_W'(s);
              r.status     = waiter_blocks[s] ? STAT_BLOCKING : STAT_ASYNC;
              r.last       = 1'b0;
              // An async waiter leaves the table; a blocking one waits for release.
              if (!waiter_blocks[s]) begin
                waiter_live[s] = 1'b0;
              end
              burst.push_back(r);
            end
          end
          if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
          end
          foreach (burst[k]) begin
            wakeups_due.push_back(burst[k]);
          end
        end
      end
      OP_CANCEL: begin
        if (cmd.req_id != '0) begin
          slot = lowest_live_slot(cmd.req_id);
          // A dispatched lowest match blocks the cancel, even with later matches.
          if (slot >= 0 && !waiter_woken[slot]) begin
            waiter_live[slot] = 1'b0;
            r.done_id    = waiter_id[slot];
            r.slot_index = OUT_SLOT_W'(slot);
            r.status     = STAT_CANCELLED;
            r.last       = 1'b1;
            wakeups_due.push_back(r);
          end
        end
      end
      default: begin
        if (cmd.req_id != '0) begin
          slot = lowest_live_slot(cmd.req_id);
          if (slot >= 0) begin
            waiter_live[slot]   = 1'b0;
            waiter_woken[slot]  = 1'b0;
            waiter_blocks[slot] = 1'b0;
          end
        end
      end
    endcase
  endtask

  // Results are checked before the command of the same edge is predicted;
  // no command can cause a result at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        waiter_live[s]   = 1'b0;
        waiter_woken[s]  = 1'b0;
        waiter_blocks[s] = 1'b0;
      end
      wakeups_due.delete();
    end else begin
      if (out_strobe !== 1'b0) begin
        if (wakeups_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing due: id %h slot %0d status %0d",
                                    out_item.done_id, out_item.slot_index, out_item.status));
        end else begin
          due = wakeups_due.pop_front();
          results_seen++;
          if (out_item.done_id !== due.done_id) begin
            report_mismatch($sformatf("done_id %h, want %h", out_item.done_id, due.done_id));
          end
          if (out_item.slot_index !== due.slot_index) begin
            report_mismatch($sformatf("slot_index %0d, want %0d",
                                      out_item.slot_index, due.slot_index));
          end
          if (out_item.status !== due.status) begin
            report_mismatch($sformatf("status %0d, want %0d", out_item.status, due.status));
          end
          if (out_item.last !== due.last) begin
            report_mismatch($sformatf("last %b, want %b (id %h)",
                                      out_item.last, due.last, due.done_id));
          end
        end
      end
      if (start && !busy) begin
        predict_command(in_item);
      end
      // At the end every result still owed counts as a failure.
      if (end_of_test && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        foreach (wakeups_due[k]) begin
          report_mismatch($sformatf("result never came: id %h slot %0d status %0d",
                                    wakeups_due[k].done_id, wakeups_due[k].slot_index,
                                    wakeups_due[k].status));
        end
      end
    end
    results_due = wakeups_due.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Waiter table testbench
// Drives wait, notify, cancel and release commands into the keyed
// wait/notify table: a directed opening over the corner cases, two runs
// that fill the table and wake every waiter at once, and random traffic on
// small id and key pools. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import kwn_pkg::*;

  localparam int ITEM_TARGET = 420;

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic start       = 1'b0;
  in_t  in_item     = '0;
  logic end_of_test = 1'b0;
  logic busy;
  logic out_strobe;
  out_t out_item;

  int mismatches;
  int results_due;
  int results_seen;
  int sent = 0;
  int op_tally [4];
  logic idling = 1'b1;
  logic [ID_W-1:0] recent_ids[$];
  logic [ID_W-1:0] fill_blocking_ids[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyed_wait_notify_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  kwn_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .end_of_test (end_of_test),
    .mismatches  (mismatches),
    .results_due (results_due),
    .results_seen(results_seen)
  );

  // Hard stop well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic in_t mk(input op_t op, input logic [ID_W-1:0] id,
                             input logic [KEY_W-1:0] key, input logic blk,
                             input logic [COUNT_W-1:0] cnt);
    in_t t;
    t.opcode      = op;
    t.req_id      = id;
    t.wait_key    = key;
    t.is_blocking = blk;
    t.wake_count  = cnt;
    return t;
  endfunction

  // Ids and keys come mostly from small pools so that commands meet waiters.
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ID_W'($urandom_range(1, 24));
    if (r < 78) return '0;
    if (r < 88) return ID_W'($urandom());
    return (r < 94) ? '1 : {1'b1, {(ID_W-1){1'b0}}};
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return KEY_W'($urandom_range(1, 6));
    if (r < 83) return '0;
    if (r < 91) return '1;
    return KEY_W'($urandom());
  endfunction

  function automatic logic [ID_W-1:0] pick_known_id();
    if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    end
    return pick_id();
  endfunction

  // One transaction: start stays high until the edge that takes it.
  task automatic send_item(input in_t item);
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    op_tally[int'(item.opcode)]++;
    if (item.opcode == OP_WAIT && item.req_id != '0) begin
      recent_ids.push_back(item.req_id);
      if (recent_ids.size() > 16) void'(recent_ids.pop_front());
    end
  endtask

  task automatic rest(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random sender gaps, switched off near the end of the run.
  task automatic maybe_rest();
    if (idling && sent < ITEM_TARGET - 40 && $urandom_range(0, 3) == 0) begin
      rest($urandom_range(1, 18));
    end
  endtask

  // Hold the sender until every owed result has come, with a bound.
  task automatic drain(input int max_cycles);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(negedge clk);
    while (results_due != 0 && waited < max_cycles) begin
      @(negedge clk);
      waited++;
    end
    @(posedge clk);
  endtask

  task automatic send_mixed();
    int r;
    int cnt;
    r = $urandom_range(0, 99);
    cnt = $urandom_range(0, 9);
    cnt = (cnt < 4) ? 0 : (cnt < 8) ? $urandom_range(1, 4) : $urandom_range(5, SLOTS);
    if (r < 45) begin
      send_item(mk(OP_WAIT, pick_id(), pick_key(), 1'($urandom_range(0, 1)),
                   COUNT_W'($urandom_range(0, SLOTS))));
    end else if (r < 70) begin
      send_item(mk(OP_NOTIFY, ID_W'($urandom()), pick_key(), 1'($urandom_range(0, 1)),
                   COUNT_W'(cnt)));
    end else if (r < 85) begin
      send_item(mk(OP_CANCEL, pick_known_id(), KEY_W'($urandom()), 1'($urandom_range(0, 1)),
                   COUNT_W'($urandom_range(0, SLOTS))));
    end else begin
      send_item(mk(OP_RELEASE, pick_known_id(), KEY_W'($urandom()), 1'($urandom_range(0, 1)),
                   COUNT_W'($urandom_range(0, SLOTS))));
    end
  endtask

  // Fill the table past full on one key, wake everyone, then free the
  // blocking waiters that the wake left behind.
  task automatic fill_table(input logic [KEY_W-1:0] fkey);
    logic [ID_W-1:0] id;
    logic            blk;
    fill_blocking_ids.delete();
    for (int n = 0; n < SLOTS + 2; n++) begin
      id  = ($urandom_range(0, 4) == 0) ? ID_W'($urandom()) : ID_W'($urandom_range(1, 200));
      if (id == '0) id = 1;
      blk = ($urandom_range(0, 3) == 0);
      if (blk && n < SLOTS) fill_blocking_ids.push_back(id);
      maybe_rest();
      send_item(mk(OP_WAIT, id, fkey, blk, COUNT_W'($urandom_range(0, SLOTS))));
    end
    maybe_rest();
    send_item(mk(OP_NOTIFY, '0, fkey, 1'b0, COUNT_W'(SLOTS)));
    drain(20000);
    foreach (fill_blocking_ids[k]) begin
      maybe_rest();
      send_item(mk(OP_RELEASE, fill_blocking_ids[k], '0, 1'b0, '0));
    end
  endtask

  initial begin
    logic second_fill;
    int   burst_len;
    second_fill = 1'b0;
    foreach (op_tally[k]) op_tally[k] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: absent ids and keys, duplicates, count zero and
    // above the match count, cancel blocked by a dispatched waiter.
    send_item(mk(OP_WAIT,    '0,            32'd5,         1'b0, '0));
    send_item(mk(OP_WAIT,    32'd7,         '0,            1'b1, '0));
    send_item(mk(OP_WAIT,    '1,            '1,            1'b0, '1));
    send_item(mk(OP_WAIT,    32'd1,         32'd1,         1'b1, '0));
    send_item(mk(OP_WAIT,    32'd2,         32'd1,         1'b0, '0));
    send_item(mk(OP_WAIT,    32'd1,         32'd1,         1'b0, '0));
    send_item(mk(OP_NOTIFY,  '0,            '0,            1'b0, 7'd5));
    send_item(mk(OP_NOTIFY,  '1,            32'd1,         1'b1, '0));
    send_item(mk(OP_CANCEL,  32'd1,         '0,            1'b0, '0));
    send_item(mk(OP_NOTIFY,  '0,            32'd1,         1'b0, COUNT_W'(SLOTS)));
    send_item(mk(OP_CANCEL,  '0,            '1,            1'b1, '1));
    send_item(mk(OP_CANCEL,  32'd12345,     '0,            1'b0, '0));
    send_item(mk(OP_RELEASE, '0,            '0,            1'b0, '0));
    send_item(mk(OP_RELEASE, 32'd1,         '0,            1'b0, '0));
    send_item(mk(OP_WAIT,    32'd3,         32'd2,         1'b1, '0));
    send_item(mk(OP_CANCEL,  32'd3,         '0,            1'b0, '0));
    send_item(mk(OP_NOTIFY,  '0,            '1,            1'b0, COUNT_W'(SLOTS)));
    send_item(mk(OP_RELEASE, 32'd99,        '0,            1'b0, '0));
    send_item(mk(OP_WAIT,    32'h8000_0000, 32'h5A5A_5A5A, 1'b1, COUNT_W'(SLOTS)));
    send_item(mk(OP_NOTIFY,  '0,            32'h5A5A_5A5A, 1'b0, 7'd1));
    send_item(mk(OP_NOTIFY,  '0,            32'h5A5A_5A5A, 1'b0, 7'd1));
    send_item(mk(OP_RELEASE, 32'h8000_0000, '0,            1'b0, '0));
    send_item(mk(OP_CANCEL,  32'h8000_0000, '0,            1'b0, '0));
    send_item(mk(OP_WAIT,    32'd5,         32'd3,         1'b0, '0));
    send_item(mk(OP_RELEASE, 32'd5,         '0,            1'b0, '0));

    // The table is empty here, so this wake reaches every slot in one notify.
    fill_table(32'hC0DE_0001);

    // Random traffic in bursts, each burst with or without sender gaps.
    while (sent < ITEM_TARGET) begin
      if (!second_fill && sent >= 240) begin
        second_fill = 1'b1;
        fill_table(32'hC0DE_0002);
      end
      idling    = ($urandom_range(0, 2) != 0);
      burst_len = $urandom_range(4, 12);
      repeat (burst_len) begin
        maybe_rest();
        send_mixed();
      end
    end

    // Let the last results and any trailing scans finish.
    drain(20000);
    repeat (200) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);

    $display("tb: %0d transactions sent (%0d wait, %0d notify, %0d cancel, %0d release)",
             sent, op_tally[int'(OP_WAIT)], op_tally[int'(OP_NOTIFY)],
             op_tally[int'(OP_CANCEL)], op_tally[int'(OP_RELEASE)]);
    $display("tb: %0d results checked, including two full-table wakeups", results_seen);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
